/* sv/mid_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the message-ID deduplication ring.
package mid_pkg;

  localparam int unsigned CAPACITY  = 256;
  localparam int unsigned IDX_W     = $clog2(CAPACITY);
  localparam int unsigned CNT_W     = $clog2(CAPACITY + 1);
  localparam int unsigned KEY_BYTES = 39;
  localparam int unsigned KEY_W     = KEY_BYTES * 8;
  localparam int unsigned LEN_W     = 6;
  localparam logic [31:0] TTL_RESET = 32'd86400000;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_COMMIT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             empty;
    logic             overlong;
    logic [31:0]      now;
    logic [KEY_W-1:0] key;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FINISH
  } back_state_t;

endpackage

/* sv/mid_in_if.sv */
`timescale 1ns / 1ps
// Input channel carrying one ID byte per beat.
interface mid_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  id_byte;
  logic        id_last;
  logic [31:0] time_ms;
  modport source (output valid, cmd, id_byte, id_last, time_ms, input ready);
  modport sink (input valid, cmd, id_byte, id_last, time_ms, output ready);
endinterface

/* sv/mid_out_if.sv */
`timescale 1ns / 1ps
// Result channel carrying the lookup outcome and the ring occupancy.
interface mid_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [8:0] stored_count;
  modport source (output valid, found, stored_count, input ready);
  modport sink (input valid, found, stored_count, output ready);
endinterface

/* sv/mid_front.sv */
`timescale 1ns / 1ps
// Front end: assembles the ID bytes and issues one job per completed ID or clear.
module mid_front (
  input  logic          clk,
  input  logic          rst_n,
  mid_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          q_push,
  output mid_pkg::job_t q_job
);

  logic [mid_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [mid_pkg::LEN_W-1:0] len_r, len_nxt;
  logic                      over_r, over_nxt;
  logic                      ended_r, ended_nxt;
  logic                      accept;
  mid_pkg::op_t              op;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign op          = mid_pkg::op_t'(in_ch.cmd);

  always_comb begin
    key_nxt   = key_r;
    len_nxt   = len_r;
    over_nxt  = over_r;
    ended_nxt = ended_r;
    q_push    = 1'b0;
    if (accept && op != mid_pkg::OP_IGNORE && op != mid_pkg::OP_CLEAR) begin
      if (!ended_r) begin
        if (in_ch.id_byte == 8'd0) begin
          ended_nxt = 1'b1;
        end else if (len_r < mid_pkg::LEN_W'(mid_pkg::KEY_BYTES)) begin
          key_nxt[8*len_r +: 8] = in_ch.id_byte;
          len_nxt               = len_r + 1'b1;
        end else begin
          over_nxt = 1'b1;
        end
      end
    end
    q_job.op       = op;
    q_job.empty    = (len_nxt == '0);
    q_job.overlong = over_nxt;
    q_job.now      = in_ch.time_ms;
    q_job.key      = key_nxt;
    if (accept && (op == mid_pkg::OP_CLEAR ||
                   (op != mid_pkg::OP_IGNORE && in_ch.id_last))) begin
      q_push    = 1'b1;
      key_nxt   = '0;
      len_nxt   = '0;
      over_nxt  = 1'b0;
      ended_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      len_r   <= '0;
      over_r  <= 1'b0;
      ended_r <= 1'b0;
    end else begin
      key_r   <= key_nxt;
      len_r   <= len_nxt;
      over_r  <= over_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

/* sv/mid_jobq.sv */
`timescale 1ns / 1ps
// Two-entry job queue between the front end and the scan engine.
module mid_jobq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mid_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output mid_pkg::job_t head_job
);

  mid_pkg::job_t slots_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    fill_r;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign head_job  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* sv/mid_back.sv */
`timescale 1ns / 1ps
// Scan engine: walks the ring newest first, expires, matches, appends and reports.
module mid_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [31:0]   ttl,
  input  logic          q_valid,
  input  mid_pkg::job_t q_job,
  output logic          q_pop,
  mid_out_if.source     out_ch
);

  localparam int unsigned IW = mid_pkg::IDX_W;
  localparam int unsigned CW = mid_pkg::CNT_W;

  logic [mid_pkg::KEY_W-1:0] id_store [mid_pkg::CAPACITY];
  logic [31:0]               seen_time [mid_pkg::CAPACITY];

  mid_pkg::back_state_t      state_r, state_nxt;
  mid_pkg::job_t             job_r, job_nxt;
  logic [CW-1:0]             i_r, i_nxt;
  logic                      hit_r, hit_nxt;
  logic [IW-1:0]             hit_idx_r, hit_idx_nxt;
  logic [mid_pkg::CAPACITY-1:0] valid_r, valid_nxt;
  logic [IW-1:0]             head_r, head_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [CW-1:0]             out_count_r, out_count_nxt;
  logic [mid_pkg::KEY_W-1:0] rd_key_r;
  logic [31:0]               rd_time_r;

  logic [IW-1:0]             idx;
  logic [IW-1:0]             slot;
  logic                      expired;
  logic                      key_we, time_we;
  logic [IW-1:0]             wr_addr;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.stored_count = out_count_r;

  assign idx     = head_r + count_r[IW-1:0] - 1'b1 - i_r[IW-1:0];
  assign expired = (job_r.now - rd_time_r) > ttl;

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    i_nxt         = i_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    valid_nxt     = valid_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_count_nxt = out_count_r;
    q_pop         = 1'b0;
    key_we        = 1'b0;
    time_we       = 1'b0;
    wr_addr       = hit_idx_r;
    slot          = head_r;
    unique case (state_r)
      mid_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          hit_nxt = 1'b0;
          i_nxt   = '0;
          if (q_job.op == mid_pkg::OP_CLEAR) begin
            valid_nxt = '0;
            head_nxt  = '0;
            count_nxt = '0;
            state_nxt = mid_pkg::ST_FINISH;
          end else if (q_job.empty || count_r == '0) begin
            state_nxt = mid_pkg::ST_FINISH;
          end else begin
            state_nxt = mid_pkg::ST_READ;
          end
        end
      end
      mid_pkg::ST_READ: begin
        state_nxt = mid_pkg::ST_CMP;
      end
      mid_pkg::ST_CMP: begin
        if (valid_r[idx] && !expired && !job_r.overlong && rd_key_r == job_r.key) begin
          hit_nxt     = 1'b1;
          hit_idx_nxt = idx;
          state_nxt   = mid_pkg::ST_FINISH;
        end else begin
          if (valid_r[idx] && expired) begin
            valid_nxt[idx] = 1'b0;
          end
          i_nxt = i_r + 1'b1;
          if (i_nxt == count_r) begin
            state_nxt = mid_pkg::ST_FINISH;
          end else begin
            state_nxt = mid_pkg::ST_READ;
          end
        end
      end
      mid_pkg::ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          if (job_r.op == mid_pkg::OP_COMMIT && !job_r.empty) begin
            time_we = 1'b1;
            if (!hit_r) begin
              if (count_r < CW'(mid_pkg::CAPACITY)) begin
                slot      = head_r + count_r[IW-1:0];
                count_nxt = count_r + 1'b1;
              end else begin
                slot     = head_r;
                head_nxt = head_r + 1'b1;
              end
              wr_addr         = slot;
              key_we          = 1'b1;
              valid_nxt[slot] = 1'b1;
            end
          end
          out_valid_nxt = 1'b1;
          out_found_nxt = hit_r;
          out_count_nxt = count_nxt;
          state_nxt     = mid_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mid_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == mid_pkg::ST_READ) begin
      rd_key_r  <= id_store[idx];
      rd_time_r <= seen_time[idx];
    end
    if (key_we) begin
      id_store[wr_addr] <= job_r.key;
    end
    if (time_we) begin
      seen_time[wr_addr] <= job_r.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mid_pkg::ST_IDLE;
      valid_r     <= '0;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    hit_idx_r   <= hit_idx_nxt;
    out_found_r <= out_found_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule

/* sv/message_id_dedup_ring_ttl.sv */
`timescale 1ns / 1ps
// Top level of the message-ID deduplication ring with time-to-live.
//
//   Port    Direction  Beat
//   in_ch   sink       cmd, id_byte, id_last, time_ms
//   out_ch  source     found, stored_count
//   cfg_*   write      ttl_ms
//
// Bytes are taken one per cycle while the job queue has room.
// A completed ID is scanned by the scan engine, through a read and a compare state
// per entry, using its single read port of the ID and time memories once per entry.
// Clear and empty-ID jobs skip the scan. Reset is synchronous and needs no
// clearing pass; the scan engine stalls only while a result beat waits.
module message_id_dedup_ring_ttl (
  input  logic        clk,
  input  logic        rst_n,
  mid_in_if.sink      in_ch,
  mid_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]   ttl_ms_r;
  logic          q_push, q_full, q_pop, q_valid;
  mid_pkg::job_t push_job, head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_ms_r <= mid_pkg::TTL_RESET;
    end else if (cfg_we) begin
      ttl_ms_r <= cfg_wdata;
    end
  end

  mid_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  mid_jobq u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_job  (head_job)
  );

  mid_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .ttl     (ttl_ms_r),
    .q_valid (q_valid),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
